>>> rtl/core/aprs_header_splitter_core_macros.svh
// ----------------------------------------------------------------------------
// APRS header splitter assertion macros
// Concurrent checks on the core clock, gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef APRS_HEADER_SPLITTER_CORE_MACROS_SVH
`define APRS_HEADER_SPLITTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Generic property, checked on every rising edge out of reset.
`define APRS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked on every rising edge out of reset.
`define APRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define APRS_ASSERT(lbl, clk, rst_n, prop, msg)
`define APRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/aprs_hs_pkg.sv
// ----------------------------------------------------------------------------
// aprs_hs_pkg
// Shared types and constants of the APRS header splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aprs_hs_pkg;

    localparam int unsigned CNT_W       = 9;
    localparam int unsigned POS_W       = 8;
    localparam int unsigned NUM_REGIONS = 4;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 72;

    // Frame limits
    localparam logic [CNT_W-1:0] MAX_FRAME_BYTES = 9'd255;
    localparam logic [CNT_W-1:0] MIN_FRAME_BYTES = 9'd10;
    localparam logic [CNT_W-1:0] COUNT_MAX       = 9'd511;
    localparam logic [POS_W-1:0] GT_MIN_POS      = 8'd1;
    localparam logic [POS_W-1:0] GT_MAX_POS      = 8'd10;
    localparam logic [POS_W-1:0] SRC_MIN_LEN     = 8'd3;
    localparam logic [POS_W-1:0] SRC_MAX_LEN     = 8'd9;

    // Separator characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // Region indexes
    localparam logic [1:0] RG_SOURCE = 2'd0;
    localparam logic [1:0] RG_DEST   = 2'd1;
    localparam logic [1:0] RG_ROUTE  = 2'd2;
    localparam logic [1:0] RG_BODY   = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_BAD_LENGTH    = 3'd1;
    localparam logic [2:0] ST_NO_GT         = 3'd2;
    localparam logic [2:0] ST_BAD_SOURCE    = 3'd3;
    localparam logic [2:0] ST_NO_COLON      = 3'd4;
    localparam logic [2:0] ST_EMPTY_PAYLOAD = 3'd5;

    // Frame summary handed to the report logic on the closing byte
    typedef struct packed {
        logic [CNT_W-1:0]                  byte_count;
        logic                              gt_found;
        logic [POS_W-1:0]                  gt_position;
        logic                              colon_found;
        logic [NUM_REGIONS-1:0]            has_text;
        logic [NUM_REGIONS-1:0][POS_W-1:0] first_text;
        logic [NUM_REGIONS-1:0][POS_W-1:0] last_text;
    } t_frame_sum;

    // Result word, status in the lowest bits
    typedef struct packed {
        logic [POS_W-1:0] body_length;
        logic [POS_W-1:0] body_start;
        logic [POS_W-1:0] route_length;
        logic [POS_W-1:0] route_start;
        logic [POS_W-1:0] dest_length;
        logic [POS_W-1:0] dest_start;
        logic [POS_W-1:0] source_length;
        logic [POS_W-1:0] source_start;
        logic [2:0]       status;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

endpackage

>>> rtl/core/aprs_hs_report.sv
// ----------------------------------------------------------------------------
// aprs_hs_report
// Builds the status and the trimmed region offsets from a frame summary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aprs_hs_report (
    input  aprs_hs_pkg::t_frame_sum i_sum,
    output aprs_hs_pkg::t_result    o_result
);
    import aprs_hs_pkg::*;

    logic [NUM_REGIONS-1:0][POS_W-1:0] w_len;
    logic [NUM_REGIONS-1:0][POS_W-1:0] w_start;
    logic                              w_bad_len;
    logic                              w_no_gt;
    logic                              w_bad_src;

    // Trimmed length wraps to 8 bits, as a 256-byte span reads as empty
    always_comb begin
        for (int r = 0; r < NUM_REGIONS; r++) begin
            if (!i_sum.has_text[r] || (i_sum.last_text[r] < i_sum.first_text[r])) begin
                w_len[r] = '0;
            end else begin
                w_len[r] = i_sum.last_text[r] - i_sum.first_text[r] + 8'd1;
            end
            w_start[r] = (w_len[r] != '0) ? i_sum.first_text[r] : '0;
        end
    end

    assign w_bad_len = (i_sum.byte_count < MIN_FRAME_BYTES) ||
                       (i_sum.byte_count > MAX_FRAME_BYTES);
    assign w_no_gt   = !i_sum.gt_found || (i_sum.gt_position < GT_MIN_POS) ||
                       (i_sum.gt_position > GT_MAX_POS);
    assign w_bad_src = (w_len[RG_SOURCE] < SRC_MIN_LEN) || (w_len[RG_SOURCE] > SRC_MAX_LEN);

    always_comb begin
        o_result = '0;
        if (w_bad_len) begin
            o_result.status = ST_BAD_LENGTH;
        end else if (w_no_gt) begin
            o_result.status = ST_NO_GT;
        end else if (w_bad_src) begin
            o_result.status = ST_BAD_SOURCE;
        end else begin
            o_result.source_start  = w_start[RG_SOURCE];
            o_result.source_length = w_len[RG_SOURCE];
            if (!i_sum.colon_found) begin
                o_result.status = ST_NO_COLON;
            end else begin
                o_result.dest_start   = w_start[RG_DEST];
                o_result.dest_length  = w_len[RG_DEST];
                o_result.route_start  = w_start[RG_ROUTE];
                o_result.route_length = w_len[RG_ROUTE];
                if (w_len[RG_BODY] == '0) begin
                    o_result.status = ST_EMPTY_PAYLOAD;
                end else begin
                    o_result.body_start  = w_start[RG_BODY];
                    o_result.body_length = w_len[RG_BODY];
                    o_result.status      = ST_OK;
                end
            end
        end
    end

endmodule

>>> rtl/core/aprs_header_splitter_core.sv
// ----------------------------------------------------------------------------
// aprs_header_splitter_core
// Splits a text frame SRC>DST,PATH:payload into trimmed region offsets.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata (low bit up)                              | tlast
//  s_axis    | in  | data_byte[7:0]                                  | frame_end
//  m_axis    | out | status, source start/len, dest start/len,       | -
//            |     | route start/len, body start/len, zero pad to 72 |
//
//  One word per cycle, unless a closing word is held back by the result
//  register; a frame result becomes valid when its closing word, held in
//  the input register, is loaded into the result register.
//  The result register alone stalls: a closing word waits in the input
//  register until the result register is free or being taken; other words
//  move on regardless.
//  Synchronous active-low reset clears the frame tracker and both valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "aprs_header_splitter_core_macros.svh"

module aprs_header_splitter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [aprs_hs_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // data_byte[7:0]
    input  logic                                 i_s_axis_tlast,  // frame_end
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // status[2:0], source_start[10:3], source_length[18:11], dest_start[26:19],
    // dest_length[34:27], route_start[42:35], route_length[50:43],
    // body_start[58:51], body_length[66:59], zero[71:67]
    output logic [aprs_hs_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import aprs_hs_pkg::*;

    // Input register
    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    // Frame tracker
    logic [CNT_W-1:0]                  r_cnt,   n_cnt;
    logic                              r_nul,   n_nul;
    logic                              r_gt_found, n_gt_found;
    logic [POS_W-1:0]                  r_gt_pos,   n_gt_pos;
    logic                              r_colon_found, n_colon_found;
    logic [POS_W-1:0]                  r_colon_pos,   n_colon_pos;
    logic                              r_comma_found, n_comma_found;
    logic [POS_W-1:0]                  r_comma_pos,   n_comma_pos;
    logic [NUM_REGIONS-1:0]            r_has,   n_has;
    logic [NUM_REGIONS-1:0][POS_W-1:0] r_first, n_first;
    logic [NUM_REGIONS-1:0][POS_W-1:0] r_last,  n_last;

    // Result register
    logic    r_out_vld;
    t_result r_out;

    logic       w_adv;
    logic       w_note;
    logic [1:0] w_region;
    logic [POS_W-1:0] w_pos;
    t_frame_sum w_sum;
    t_result    w_result;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    // Closing words need room in the result register; the rest always advance
    assign w_adv           = r_in_vld && (!r_in_last || !r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || w_adv;

    assign w_pos = r_cnt[POS_W-1:0];

    // Classify the held byte and advance the tracker
    always_comb begin
        n_cnt         = (r_cnt != COUNT_MAX) ? r_cnt + 9'd1 : r_cnt;
        n_nul         = r_nul || (r_in_byte == CH_NUL);
        n_gt_found    = r_gt_found;
        n_gt_pos      = r_gt_pos;
        n_colon_found = r_colon_found;
        n_colon_pos   = r_colon_pos;
        n_comma_found = r_comma_found;
        n_comma_pos   = r_comma_pos;
        n_has         = r_has;
        n_first       = r_first;
        n_last        = r_last;
        w_note        = 1'b0;
        w_region      = RG_SOURCE;

        // Skip everything from the first NUL on, and positions past 255
        if (!n_nul && !r_cnt[CNT_W-1]) begin
            if (!r_gt_found) begin
                if (r_in_byte == CH_GT) begin
                    n_gt_found = 1'b1;
                    n_gt_pos   = w_pos;
                end else begin
                    w_note   = 1'b1;
                    w_region = RG_SOURCE;
                end
            end else if (!r_colon_found) begin
                if (r_in_byte == CH_COLON) begin
                    n_colon_found = 1'b1;
                    n_colon_pos   = w_pos;
                end else if (!r_comma_found && (r_in_byte == CH_COMMA)) begin
                    n_comma_found = 1'b1;
                    n_comma_pos   = w_pos;
                end else begin
                    w_note   = 1'b1;
                    w_region = r_comma_found ? RG_ROUTE : RG_DEST;
                end
            end else begin
                w_note   = 1'b1;
                w_region = RG_BODY;
            end
        end

        // Track first and last non-blank positions of the region
        if (w_note && !is_blank(r_in_byte)) begin
            if (!r_has[w_region]) begin
                n_has[w_region]   = 1'b1;
                n_first[w_region] = w_pos;
            end
            n_last[w_region] = w_pos;
        end
    end

    always_comb begin
        w_sum.byte_count  = n_cnt;
        w_sum.gt_found    = n_gt_found;
        w_sum.gt_position = n_gt_pos;
        w_sum.colon_found = n_colon_found;
        w_sum.has_text    = n_has;
        w_sum.first_text  = n_first;
        w_sum.last_text   = n_last;
    end

    aprs_hs_report u_report (
        .i_sum    (w_sum),
        .o_result (w_result)
    );

    // Input register: load on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Tracker: update on each advancing word, drop back to empty after a close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_adv && r_in_last)) begin
            r_cnt         <= '0;
            r_nul         <= 1'b0;
            r_gt_found    <= 1'b0;
            r_gt_pos      <= '0;
            r_colon_found <= 1'b0;
            r_colon_pos   <= '0;
            r_comma_found <= 1'b0;
            r_comma_pos   <= '0;
            r_has         <= '0;
            r_first       <= '0;
            r_last        <= '0;
        end else if (w_adv) begin
            r_cnt         <= n_cnt;
            r_nul         <= n_nul;
            r_gt_found    <= n_gt_found;
            r_gt_pos      <= n_gt_pos;
            r_colon_found <= n_colon_found;
            r_colon_pos   <= n_colon_pos;
            r_comma_found <= n_comma_found;
            r_comma_pos   <= n_comma_pos;
            r_has         <= n_has;
            r_first       <= n_first;
            r_last        <= n_last;
        end
    end

    // Result register: fill on a closing word, drain when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, r_out};

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    `APRS_ASSERT_IMPL(a_midframe_never_stalls, i_clk, i_rst_n, r_in_vld && !r_in_last, o_s_axis_tready, "mid-frame word stalled the input")

    `APRS_ASSERT_IMPL(a_ok_has_body, i_clk, i_rst_n, r_out_vld && (r_out.status == ST_OK), r_out.body_length != '0, "ok status with empty body")

    `APRS_ASSERT_IMPL(a_early_fail_zero, i_clk, i_rst_n, r_out_vld && ((r_out.status == ST_BAD_LENGTH) || (r_out.status == ST_NO_GT)), r_out[RESULT_W-1:3] == '0, "region fields set on early failure")

    `APRS_ASSERT(a_clear_after_close, i_clk, i_rst_n, (w_adv && r_in_last) |=> ((r_cnt == '0) && !r_gt_found && !r_nul && (r_has == '0) && r_out_vld), "tracker not cleared after frame close")

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the APRS header splitter. Frames are fed one byte
// per word. A predictor tracks the separators and the trimmed regions in the
// same way as the core does. The expected frame report is queued when the
// closing byte is accepted, and each report that the core emits is compared
// field by field with the oldest queued one. The tests cover hand-made
// frames, the length limits, random frames under several idle mixes, and a
// long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import aprs_hs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 300;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // data_byte[7:0]
    logic                   i_s_axis_tlast = 1'b0; // frame_end
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;        // t_result, zero pad on top

    aprs_header_splitter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Frame tracker of the predictor
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] byte_count;
    bit               nul_seen;
    bit               gt_found;
    logic [POS_W-1:0] gt_position;
    bit               colon_found;
    bit               comma_found;
    bit               has_text [NUM_REGIONS];
    logic [POS_W-1:0] first_text [NUM_REGIONS];
    logic [POS_W-1:0] last_text [NUM_REGIONS];

    t_result    pending_reports[$];
    logic [7:0] frame_buf[$];

    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_left = 0;
    int idle_cycles = 0;
    int random_words = 0;

    function automatic void clear_frame_tracker();
        byte_count = '0;
        nul_seen = 1'b0;
        gt_found = 1'b0;
        gt_position = '0;
        colon_found = 1'b0;
        comma_found = 1'b0;
        for (int r = 0; r < NUM_REGIONS; r++) begin
            has_text[r] = 1'b0;
            first_text[r] = '0;
            last_text[r] = '0;
        end
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic void mark_text(input logic [1:0] rg, input logic [POS_W-1:0] pos,
                                      input logic [7:0] b);
        if (is_blank(b))
            return;
        if (!has_text[rg]) begin
            has_text[rg] = 1'b1;
            first_text[rg] = pos;
        end
        last_text[rg] = pos;
    endfunction

    function automatic logic [POS_W-1:0] trimmed_length(input logic [1:0] rg);
        if (!has_text[rg] || last_text[rg] < first_text[rg])
            return '0;
        return last_text[rg] - first_text[rg] + 8'd1;
    endfunction

    function automatic void region_span(input logic [1:0] rg, output logic [POS_W-1:0] start,
                                        output logic [POS_W-1:0] length);
        length = trimmed_length(rg);
        start = (length != 0) ? first_text[rg] : '0;
    endfunction

    // Advance the tracker by one accepted byte; queue a report on the closing one.
    function automatic void track_frame_byte(input logic [7:0] b, input logic last);
        logic [CNT_W-1:0] pos;
        logic [POS_W-1:0] src_len;
        t_result          rep;
        pos = byte_count;
        if (b == CH_NUL)
            nul_seen = 1'b1;
        if (!nul_seen && pos <= 9'd255) begin
            if (!gt_found) begin
                if (b == CH_GT) begin
                    gt_found = 1'b1;
                    gt_position = pos[POS_W-1:0];
                end else begin
                    mark_text(RG_SOURCE, pos[POS_W-1:0], b);
                end
            end else if (!colon_found) begin
                if (b == CH_COLON)
                    colon_found = 1'b1;
                else if (!comma_found && b == CH_COMMA)
                    comma_found = 1'b1;
                else
                    mark_text(comma_found ? RG_ROUTE : RG_DEST, pos[POS_W-1:0], b);
            end else begin
                mark_text(RG_BODY, pos[POS_W-1:0], b);
            end
        end
        if (byte_count < COUNT_MAX)
            byte_count++;
        if (!last)
            return;

        rep = '0;
        src_len = trimmed_length(RG_SOURCE);
        if (byte_count < MIN_FRAME_BYTES || byte_count > MAX_FRAME_BYTES) begin
            rep.status = ST_BAD_LENGTH;
        end else if (!gt_found || gt_position < GT_MIN_POS || gt_position > GT_MAX_POS) begin
            rep.status = ST_NO_GT;
        end else if (src_len < SRC_MIN_LEN || src_len > SRC_MAX_LEN) begin
            rep.status = ST_BAD_SOURCE;
        end else begin
            region_span(RG_SOURCE, rep.source_start, rep.source_length);
            if (!colon_found) begin
                rep.status = ST_NO_COLON;
            end else begin
                region_span(RG_DEST, rep.dest_start, rep.dest_length);
                region_span(RG_ROUTE, rep.route_start, rep.route_length);
                if (trimmed_length(RG_BODY) == 0) begin
                    rep.status = ST_EMPTY_PAYLOAD;
                end else begin
                    region_span(RG_BODY, rep.body_start, rep.body_length);
                    rep.status = ST_OK;
                end
            end
        end
        pending_reports.push_back(rep);
        clear_frame_tracker();
    endfunction

    // ------------------------------------------------------------------
    // Input side: one word per call, with a random gap ahead of it
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        i_s_axis_tlast <= last;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        track_frame_byte(b, last);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_word(frame_buf[i], i == frame_buf.size() - 1);
        frame_buf.delete();
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_buf.push_back(s[i]);
    endfunction

    // Printable text, now and then whitespace; separators only when allowed.
    function automatic logic [7:0] pick_char(input bit allow_sep);
        logic [7:0] c;
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'h20 : 8'($urandom_range(9, 13));
        do
            c = 8'($urandom_range(33, 126));
        while (!allow_sep && (c == CH_GT || c == CH_COLON || c == CH_COMMA));
        return c;
    endfunction

    function automatic void add_chars(input int n, input bit allow_sep);
        repeat (n) frame_buf.push_back(pick_char(allow_sep));
    endfunction

    // Mostly SRC>DST[,PATH]:BODY with random sizes, some noise and some damage.
    function automatic void build_random_frame();
        int body_n;
        frame_buf.delete();
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom_range(255)));
            return;
        end
        add_chars(($urandom_range(4) == 0) ? $urandom_range(0, 12) : $urandom_range(3, 9), 0);
        if ($urandom_range(15) != 0)
            frame_buf.push_back(CH_GT);
        add_chars($urandom_range(0, 6), 0);
        if ($urandom_range(2) != 0) begin
            frame_buf.push_back(CH_COMMA);
            add_chars($urandom_range(0, 15), 1);
        end
        if ($urandom_range(15) != 0)
            frame_buf.push_back(CH_COLON);
        body_n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
        if ($urandom_range(29) == 0)
            body_n = $urandom_range(200, 260);
        add_chars(body_n, 1);
        if (frame_buf.size() == 0)
            frame_buf.push_back(pick_char(1));
        if ($urandom_range(9) == 0)
            frame_buf[$urandom_range(frame_buf.size() - 1)] = 8'($urandom_range(255));
        if ($urandom_range(11) == 0)
            frame_buf[$urandom_range(frame_buf.size() - 1)] = CH_NUL;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls, or a counted hold-off when one is asked
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] wanted,
                                        input logic [7:0] actual);
        if (actual !== wanted) begin
            $error("%s: expected %0d, got %0d", name, wanted, actual);
            fail_count++;
        end
    endfunction

    t_result got_report;
    t_result want_report;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_report = o_m_axis_tdata[RESULT_W-1:0];
            if (pending_reports.size() == 0) begin
                $error("report with status %0d arrived with none expected", got_report.status);
                fail_count++;
            end else begin
                want_report = pending_reports.pop_front();
                check_field("status", 8'(want_report.status), 8'(got_report.status));
                check_field("source_start", want_report.source_start, got_report.source_start);
                check_field("source_length", want_report.source_length,
                            got_report.source_length);
                check_field("dest_start", want_report.dest_start, got_report.dest_start);
                check_field("dest_length", want_report.dest_length, got_report.dest_length);
                check_field("route_start", want_report.route_start, got_report.route_start);
                check_field("route_length", want_report.route_length, got_report.route_length);
                check_field("body_start", want_report.body_start, got_report.body_start);
                check_field("body_length", want_report.body_length, got_report.body_length);
                check_field("pad", '0, 8'(o_m_axis_tdata[OUT_TDATA_W-1:RESULT_W]));
            end
        end
    end

    // Drop out when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_frames();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_text("N0CALL>APRS,WIDE1-1,WIDE2-1:!4903.50N/07201.75W-Hi");
        send_frame();
        // whitespace around every region, no path
        add_text(" \tAB1CD \r>\n APX  :  hi there ");
        frame_buf.push_back(8'h0B);
        send_frame();
        add_text(">ABCDEF:payload");            // '>' at the very first byte
        send_frame();
        add_text("ABCDEFGHIJK>X:yy");           // '>' one past the last allowed spot
        send_frame();
        add_text("ABCDEFGHI >X:yy");            // '>' at the last allowed spot
        send_frame();
        add_text("ABCDEFGHIJ>X:yy");            // source one too long
        send_frame();
        add_text("AB  >CDEFGH:zz");             // source one too short
        send_frame();
        add_text("ABC>DEFGHIJKLMN");            // no colon
        send_frame();
        add_text("ABC:DEF>GH,IJ:body");         // colon ahead of '>' is source text
        send_frame();
        add_text("ABC>DEFGH:  \t \n");          // payload of blanks only
        send_frame();
        add_text("ABC>D,,,:x>:,");              // extra separators are plain text
        send_frame();
        add_text("ABC>:body text");             // empty destination
        send_frame();
        add_text("ABC>DEF,:x");                 // empty path
        send_frame();
        add_text("ABC>DEF:xy");                 // NUL inside the payload
        frame_buf.push_back(CH_NUL);
        add_text("zz:zz");
        send_frame();
        add_text("AB");                         // NUL inside the source hides '>'
        frame_buf.push_back(CH_NUL);
        add_text("CDE>FG:hi");
        send_frame();
        add_text("ABC>DEF:");                   // NUL right after the colon
        frame_buf.push_back(CH_NUL);
        add_text("abc");
        send_frame();
        add_text("ABC>DEF:");                   // high and top-bit bytes as payload
        frame_buf.push_back(8'hFF);
        frame_buf.push_back(8'h80);
        frame_buf.push_back(8'h7F);
        send_frame();
        add_text("X");                          // single-byte frame
        send_frame();
    endtask

    task automatic test_length_limits();
        int sizes[4];
        sizes = '{9, 10, 255, 256};
        send_idle_pct = 37;
        recv_stall_pct = 37;
        foreach (sizes[i]) begin
            add_text("ABC>DEF:");
            add_chars(sizes[i] - 8, 1);
            send_frame();
        end
    endtask

    task automatic test_random_frames();
        int idle_mix[4][2];
        idle_mix = '{'{0, 0}, '{85, 0}, '{0, 85}, '{37, 37}};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_mix[ph][0];
            recv_stall_pct = idle_mix[ph][1];
            while (random_words < (ph + 1) * RANDOM_WORDS / 4) begin
                build_random_frame();
                random_words += frame_buf.size();
                send_frame();
            end
        end
    endtask

    // Receiver holds off while frames keep coming, so the core fills and stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 20;
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (6) begin
            add_text("N0CALL>APRS:status ");
            add_chars($urandom_range(1, 8), 1);
            send_frame();
        end
    endtask

    initial begin
        clear_frame_tracker();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_length_limits();
        test_random_frames();
        test_backpressure();

        i_s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/aprs_hs_pkg.sv
rtl/core/aprs_hs_report.sv
rtl/core/aprs_header_splitter_core.sv
tb/tb_top.sv
